// File: rtl/itkf_pkg.sv
// Package for the IMU tilt Kalman filter: constants, command and status types.
// Used by every module under rtl/.
package itkf_pkg;

  localparam int DataW      = 16;
  localparam int CordicW    = 28;   // 16-bit input scaled by 256, plus growth
  localparam int ZW         = 26;   // angle accumulator, Q.16 degrees
  localparam int AtanLen    = 24;
  localparam logic [24:0] DtQ24    = 25'd117441;
  localparam logic [31:0] ProcQ24  = 32'd13153;
  localparam logic [35:0] NoiseQ24 = 36'd150994944;
  localparam int DivSteps   = 25;   // quotient bits of the gain division

  // Register indexes on the configuration port.
  localparam logic CfgGyroOffX = 1'b0;
  localparam logic CfgGyroOffY = 1'b1;

  // CORDIC rotation table, degrees in Q.16.
  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0: v = 26'd2949120;   5'd1: v = 26'd1740967;
      5'd2: v = 26'd919879;    5'd3: v = 26'd466945;
      5'd4: v = 26'd234379;    5'd5: v = 26'd117304;
      5'd6: v = 26'd58666;     5'd7: v = 26'd29335;
      5'd8: v = 26'd14668;     5'd9: v = 26'd7334;
      5'd10: v = 26'd3667;     5'd11: v = 26'd1833;
      5'd12: v = 26'd917;      5'd13: v = 26'd458;
      5'd14: v = 26'd229;      5'd15: v = 26'd115;
      5'd16: v = 26'd57;       5'd17: v = 26'd29;
      5'd18: v = 26'd14;       5'd19: v = 26'd7;
      5'd20: v = 26'd4;        5'd21: v = 26'd2;
      5'd22: v = 26'd1;        default: v = '0;
    endcase
    return v;
  endfunction

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture item, start both CORDICs
    OP_CORDIC,    // one CORDIC iteration on both angles
    OP_ANGLES,    // round and offset the accelerometer angles
    OP_PREDICT,   // gyro prediction and uncertainty term for current axis
    OP_DIV_INIT,  // set up gain division
    OP_DIV_STEP,  // one quotient bit
    OP_GAIN,      // round the gain
    OP_MUL_UPD,   // K times innovation
    OP_MUL_UNC,   // P times (1 - K), write back the axis
    OP_OUTPUT     // load the result register
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;   // 0: y axis, 1: x axis
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // result register holds an item that is not taken this cycle
  } stat_t;

endpackage

// File: rtl/itkf_datapath.sv
// Datapath of the IMU tilt Kalman filter: CORDIC atan2 pair, gain divider,
// filter state and result register. Depends on itkf_pkg.
module itkf_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itkf_pkg::cmd_t       cmd,
  output itkf_pkg::stat_t      stat,
  input  logic [79:0]          in_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_data
);

  localparam int CW = itkf_pkg::CordicW;
  localparam int ZW = itkf_pkg::ZW;

  logic signed [15:0] off_x_r, off_y_r;
  logic signed [15:0] gx_r, gy_r;
  // CORDIC pair: a works on (az, ay), b on (az, ax).
  logic signed [CW-1:0] xa_r, ya_r, xb_r, yb_r;
  logic signed [ZW-1:0] za_r, zb_r;
  logic zero_a_r, zero_b_r;
  logic [4:0] it_r;
  logic signed [15:0] ang_x_r;
  logic signed [14:0] ang_y_r;
  // Filter state.
  logic signed [31:0] est_x_r, est_y_r;
  logic [31:0] unc_x_r, unc_y_r;
  // Working registers for the current axis.
  logic signed [33:0] a_r;       // predicted angle
  logic [31:0] p_r;              // predicted uncertainty
  logic [36:0] rem_r;            // divider remainder
  logic [35:0] den_r;
  logic [25:0] q_r;              // quotient with one extra fraction bit
  logic [24:0] k_r;              // gain, Q.24
  logic out_valid_r;
  logic [63:0] out_data_r;

  // Per-iteration CORDIC step.
  function automatic void cstep(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                input logic signed [ZW-1:0] z, input logic [4:0] i,
                                output logic signed [CW-1:0] xo,
                                output logic signed [CW-1:0] yo,
                                output logic signed [ZW-1:0] zo);
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] t;
    dx = y >>> i;
    dy = x >>> i;
    t  = itkf_pkg::atan_q16(i);
    if (y > 0) begin
      xo = x + dx; yo = y - dy; zo = z + t;
    end else begin
      xo = x - dx; yo = y + dy; zo = z - t;
    end
  endfunction

  // Initial quadrant turn for atan2(y, x).
  function automatic void cinit(input logic signed [15:0] y, input logic signed [15:0] x,
                                output logic signed [CW-1:0] xo,
                                output logic signed [CW-1:0] yo,
                                output logic signed [ZW-1:0] zo);
    logic signed [CW-1:0] xs, ys;
    xs = CW'(x) <<< 8;
    ys = CW'(y) <<< 8;
    if (x < 0 && y >= 0) begin
      xo = ys; yo = -xs; zo = ZW'(90 * 65536);
    end else if (x < 0) begin
      xo = -ys; yo = xs; zo = -ZW'(90 * 65536);
    end else begin
      xo = xs; yo = ys; zo = '0;
    end
  endfunction

  logic signed [CW-1:0] xa_n, ya_n, xb_n, yb_n, xa_i, ya_i, xb_i, yb_i;
  logic signed [ZW-1:0] za_n, zb_n, za_i, zb_i;
  always_comb begin
    cstep(xa_r, ya_r, za_r, it_r, xa_n, ya_n, za_n);
    cstep(xb_r, yb_r, zb_r, it_r, xb_n, yb_n, zb_n);
    cinit(in_data[31:16], in_data[47:32], xa_i, ya_i, za_i);
    cinit(in_data[15:0], in_data[47:32], xb_i, yb_i, zb_i);
  end

  // Rounded CORDIC results in 1/64 degree.
  logic signed [ZW-1:0] za_rnd, zb_rnd;
  logic signed [15:0] angx_raw, angx_off;
  always_comb begin
    za_rnd = (za_r + ZW'(512)) >>> 10;
    zb_rnd = (zb_r + ZW'(512)) >>> 10;
    angx_raw = zero_a_r ? 16'sd0 : za_rnd[15:0];
    if (angx_raw < -16'sd5760) angx_off = angx_raw + 16'sd11520;
    else                       angx_off = angx_raw - 16'sd11520;
  end

  // Prediction for the selected axis.
  logic signed [16:0] rate;
  logic signed [42:0] rate_dt;
  logic signed [33:0] a_pred, a_sum;
  logic signed [31:0] est_cur;
  logic [31:0] unc_cur;
  always_comb begin
    est_cur = cmd.axis ? est_x_r : est_y_r;
    unc_cur = cmd.axis ? unc_x_r : unc_y_r;
    rate = cmd.axis ? (17'(gx_r) - 17'(off_x_r)) : (17'(off_y_r) - 17'(gy_r));
    rate_dt = 43'(rate) * $signed({18'd0, itkf_pkg::DtQ24});
    a_sum = 34'(est_cur) + 34'((rate_dt + 43'sd2048) >>> 12);
    if (a_sum > 34'sh7FFFFFFF) a_pred = 34'sh7FFFFFFF;
    else if (a_sum < -34'sh80000000) a_pred = -34'sh80000000;
    else a_pred = a_sum;
  end

  // Update products.
  logic signed [15:0] meas;
  logic signed [35:0] innov;
  logic signed [61:0] kprod;
  logic signed [35:0] a_new, a_sat;
  logic [25:0] one_m_k;
  logic [57:0] pprod;
  always_comb begin
    meas = cmd.axis ? ang_x_r : 16'(ang_y_r);
    innov = (36'(meas) <<< 10) - 36'(a_r);
    kprod = 62'(innov) * $signed({37'd0, k_r});
    a_new = 36'(a_r) + 36'((kprod + 62'sd8388608) >>> 24);
    if (a_new > 36'sh7FFFFFFF) a_sat = 36'sh7FFFFFFF;
    else if (a_new < -36'sh80000000) a_sat = -36'sh80000000;
    else a_sat = a_new;
    one_m_k = 26'd16777216 - 26'(k_r);
    pprod = 58'(p_r) * 58'(one_m_k);
  end

  // Divider step: restoring, one bit each cycle, zeros shift in below the remainder.
  logic [36:0] rem_sh;
  always_comb rem_sh = {rem_r[35:0], 1'b0};

  // Output saturation.
  function automatic logic [15:0] sat_out(input logic signed [31:0] v);
    logic signed [22:0] r;
    r = 23'((33'(v) + 33'sd512) >>> 10);
    if (r > 23'sd32767) return 16'h7FFF;
    if (r < -23'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0; off_y_r <= '0;
      est_x_r <= '0; est_y_r <= '0;
      unc_x_r <= '0; unc_y_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == itkf_pkg::CfgGyroOffX) off_x_r <= cfg_wdata;
        else                                    off_y_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        itkf_pkg::OP_LOAD: begin
          {gy_r, gx_r} <= in_data[79:48];
          xa_r <= xa_i; ya_r <= ya_i; za_r <= za_i;
          xb_r <= xb_i; yb_r <= yb_i; zb_r <= zb_i;
          zero_a_r <= (in_data[31:16] == 16'd0) && (in_data[47:32] == 16'd0);
          zero_b_r <= (in_data[15:0] == 16'd0) && (in_data[47:32] == 16'd0);
          it_r <= '0;
        end
        itkf_pkg::OP_CORDIC: begin
          xa_r <= xa_n; ya_r <= ya_n; za_r <= za_n;
          xb_r <= xb_n; yb_r <= yb_n; zb_r <= zb_n;
          it_r <= it_r + 5'd1;
        end
        itkf_pkg::OP_ANGLES: begin
          ang_x_r <= angx_off;
          ang_y_r <= zero_b_r ? 15'sd0 : zb_rnd[14:0];
        end
        itkf_pkg::OP_PREDICT: begin
          a_r <= a_pred;
          p_r <= unc_cur + itkf_pkg::ProcQ24;
        end
        itkf_pkg::OP_DIV_INIT: begin
          // Quotient of p * 2^25 / den gives one bit for rounding; p < den,
          // so the remainder starts at p and 25 steps give every quotient bit.
          den_r <= 36'(p_r) + itkf_pkg::NoiseQ24;
          rem_r <= 37'(p_r);
          q_r <= '0;
        end
        itkf_pkg::OP_DIV_STEP: begin
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= rem_sh - {1'b0, den_r};
            q_r <= {q_r[24:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r <= {q_r[24:0], 1'b0};
          end
        end
        itkf_pkg::OP_GAIN: k_r <= 25'((27'(q_r) + 27'd1) >> 1);
        itkf_pkg::OP_MUL_UPD: a_r <= a_sat[33:0];
        itkf_pkg::OP_MUL_UNC: begin
          if (cmd.axis) begin
            est_x_r <= a_r[31:0];
            unc_x_r <= 32'((pprod + 58'd8388608) >> 24);
          end else begin
            est_y_r <= a_r[31:0];
            unc_y_r <= 32'((pprod + 58'd8388608) >> 24);
          end
        end
        itkf_pkg::OP_OUTPUT: begin
          out_valid_r <= 1'b1;
          out_data_r <= {1'b0, ang_y_r, ang_x_r, sat_out(est_y_r), sat_out(est_x_r)};
        end
        default: ;
      endcase
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/itkf_ctrl.sv
// Controller of the IMU tilt Kalman filter: sequences CORDIC, division and
// filter updates. Depends on itkf_pkg.
module itkf_ctrl #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  itkf_pkg::stat_t stat,
  output itkf_pkg::cmd_t  cmd
);

  localparam int CntW = 5;
  localparam logic [CntW-1:0] CordLast = CntW'(CORDIC_ITERATIONS - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(itkf_pkg::DivSteps - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_ANGLES, S_PREDICT, S_DIV_INIT, S_DIV,
    S_GAIN, S_UPD, S_UNC, S_WAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [CntW-1:0] cnt_r;
  logic axis_r;

  assign in_ready = (state_r == S_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd.axis = axis_r;
    unique case (state_r)
      S_IDLE:     cmd.op = in_valid ? itkf_pkg::OP_LOAD : itkf_pkg::OP_NONE;
      S_CORDIC:   cmd.op = itkf_pkg::OP_CORDIC;
      S_ANGLES:   cmd.op = itkf_pkg::OP_ANGLES;
      S_PREDICT:  cmd.op = itkf_pkg::OP_PREDICT;
      S_DIV_INIT: cmd.op = itkf_pkg::OP_DIV_INIT;
      S_DIV:      cmd.op = itkf_pkg::OP_DIV_STEP;
      S_GAIN:     cmd.op = itkf_pkg::OP_GAIN;
      S_UPD:      cmd.op = itkf_pkg::OP_MUL_UPD;
      S_UNC:      cmd.op = itkf_pkg::OP_MUL_UNC;
      S_OUT:      cmd.op = itkf_pkg::OP_OUTPUT;
      default:    cmd.op = itkf_pkg::OP_NONE;
    endcase
  end

  // State sequence; axis 0 (y) is filtered before axis 1 (x).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      axis_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          state_r <= S_CORDIC; cnt_r <= '0;
        end
        S_CORDIC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CordLast) state_r <= S_ANGLES;
        end
        S_ANGLES: begin
          state_r <= S_PREDICT; axis_r <= 1'b0;
        end
        S_PREDICT:  state_r <= S_DIV_INIT;
        S_DIV_INIT: begin
          state_r <= S_DIV; cnt_r <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DivLast) state_r <= S_GAIN;
        end
        S_GAIN: state_r <= S_UPD;
        S_UPD:  state_r <= S_UNC;
        S_UNC: begin
          if (!axis_r) begin
            axis_r <= 1'b1; state_r <= S_PREDICT;
          end else state_r <= S_WAIT;
        end
        S_WAIT: if (!stat.out_busy) state_r <= S_OUT;
        S_OUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/imu_tilt_kalman_filter.sv
// Top level of the IMU tilt Kalman filter: controller plus datapath.
// Depends on itkf_pkg, itkf_ctrl and itkf_datapath.
//
// The CORDIC unit runs both atan2 angles side by side, one iteration a cycle,
// and each axis then needs a restoring division for the Kalman gain.
// A new item is taken once the previous one has moved to the result register.
module imu_tilt_kalman_filter #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // tilt_x, tilt_y, accel_angle_x, accel_angle_y(15), 0
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  itkf_pkg::cmd_t  cmd;
  itkf_pkg::stat_t stat;

  itkf_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .stat, .cmd
  );

  itkf_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_data(in_tdata),
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata)
  );

endmodule

// File: sim/tb_imu_tilt_kalman_filter.sv
// Testbench for the IMU tilt Kalman filter: drives raw sample items and checks
// the filtered and accelerometer angles against a bit-exact predictor.
// Depends on itkf_pkg and the imu_tilt_kalman_filter RTL.
`timescale 1ns / 100ps

module tb_imu_tilt_kalman_filter;

  localparam int Iters = 16;
  localparam int WatchLimit = 20000;

  // Packed from the top bit down, so tilt_x lands in the lowest bits.
  typedef struct packed {
    logic signed [14:0] acc_ang_y;
    logic signed [15:0] acc_ang_x;
    logic signed [15:0] tilt_y;
    logic signed [15:0] tilt_x;
  } tilt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;   // accel_x, accel_y, accel_z, gyro_x, gyro_y
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;       // tilt_x, tilt_y, accel_angle_x, accel_angle_y(15), 0
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Predictor state.
  longint est_x, est_y, unc_x, unc_y, off_x, off_y;
  tilt_t pending_tilts[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  imu_tilt_kalman_filter #(.CORDIC_ITERATIONS(Iters)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Vectoring CORDIC, result in 1/64 degree.
  function automatic longint atan2_q6(longint yy, longint xx);
    longint x, y, z, t, dx, dy;
    if (xx == 0 && yy == 0) return 0;
    x = xx * 256;
    y = yy * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < Iters && i < itkf_pkg::AtanLen; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(itkf_pkg::atan_q16(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(itkf_pkg::atan_q16(i[4:0]));
      end
    end
    return round_sh(z, 10);
  endfunction

  // One scalar Kalman update for an axis.
  task automatic kalman_axis(inout longint est, inout longint unc, input longint rate,
                             input longint meas);
    longint a, p, den, k;
    longint one;
    one = longint'(1) <<< 24;
    a = clip(est + round_sh(rate * 117441, 12), -64'sd2147483648, 64'sd2147483647);
    p = unc + 13153;
    den = p + 9 * one;
    k = ((p <<< 24) + den / 2) / den;
    a += round_sh((meas * 1024 - a) * k, 24);
    a = clip(a, -64'sd2147483648, 64'sd2147483647);
    p = (p * (one - k) + (one >>> 1)) >>> 24;
    est = a;
    unc = p;
  endtask

  task automatic predict_tilt(input logic [79:0] d);
    longint ax, ay, az, gx, gy, angx, angy;
    tilt_t r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    angx = atan2_q6(ay, az);
    angy = atan2_q6(ax, az);
    if (angx < -90 * 64) angx += 180 * 64;
    else angx -= 180 * 64;
    kalman_axis(est_y, unc_y, -(gy - off_y), angy);
    kalman_axis(est_x, unc_x, gx - off_x, angx);
    r.tilt_x = 16'(clip(round_sh(est_x, 10), -32768, 32767));
    r.tilt_y = 16'(clip(round_sh(est_y, 10), -32768, 32767));
    r.acc_ang_x = 16'(angx);
    r.acc_ang_y = 15'(angy);
    pending_tilts.push_back(r);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Result checker: compares each accepted output with the next predicted item.
  always @(posedge clk) begin
    tilt_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[62:0];
      if (out_tdata[63] !== 1'b0) report("pad bit", out_tdata[63], 0);
      if (pending_tilts.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        want = pending_tilts.pop_front();
        if (got.tilt_x !== want.tilt_x) report("tilt_x", got.tilt_x, want.tilt_x);
        if (got.tilt_y !== want.tilt_y) report("tilt_y", got.tilt_y, want.tilt_y);
        if (got.acc_ang_x !== want.acc_ang_x)
          report("accel_angle_x", got.acc_ang_x, want.acc_ang_x);
        if (got.acc_ang_y !== want.acc_ang_y)
          report("accel_angle_y", got.acc_ang_y, want.acc_ang_y);
      end
    end
  end

  // Output ready: bursts of stall unless in the quiet tail.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic [79:0] d);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tilt(d);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_tilts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_offset(input logic idx, input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == itkf_pkg::CfgGyroOffX) off_x = longint'($signed(v));
    else off_y = longint'($signed(v));
  endtask

  function automatic logic [79:0] pack5(int ax, int ay, int az, int gx, int gy);
    return {16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  // Field extremes and the atan2 corner cases.
  task automatic test_directed;
    send_sample(pack5(0, 0, 0, 0, 0));
    send_sample(pack5(0, 0, -100, 0, 0));
    send_sample(pack5(0, -100, -100, 0, 0));
    send_sample(pack5(-100, 100, -1, 0, 0));
    send_sample(pack5(0, 0, 1000, 0, 0));
    send_sample(pack5(32767, 32767, 32767, 32767, 32767));
    send_sample(pack5(-32768, -32768, -32768, -32768, -32768));
    send_sample(pack5(-32768, 32767, 0, 32767, -32768));
    send_sample(pack5(1, -1, 0, 0, 0));
    send_sample(pack5(0, 1000, 1, -1, 1));
    send_sample(pack5(0, -1000, 1, 0, 0));
    send_sample(pack5(500, 500, 707, 100, -100));
    drain();
    write_offset(itkf_pkg::CfgGyroOffX, 16'h7fff);
    write_offset(itkf_pkg::CfgGyroOffY, 16'h8000);
    send_sample(pack5(10, 20, 1000, -32768, 32767));
    send_sample(pack5(10, 20, 1000, 32767, -32768));
    drain();
  endtask

  // Drive the filter into saturation with a constant large rate.
  task automatic test_saturation;
    write_offset(itkf_pkg::CfgGyroOffX, 16'h8000);
    write_offset(itkf_pkg::CfgGyroOffY, 16'h7fff);
    repeat (60) send_sample(pack5(0, 0, 1000, 32767, -32768));
    drain();
  endtask

  // Random items under the current offset settings; level-ish samples dominate.
  task automatic test_random(input int count, input bit gentle);
    logic [79:0] d;
    for (int i = 0; i < count; i++) begin
      if (gentle || $urandom_range(0, 3) != 0)
        d = pack5($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                  $urandom_range(0, 2000) + 500, $urandom_range(0, 200) - 100,
                  $urandom_range(0, 200) - 100);
      else d = 80'({$urandom(), $urandom(), $urandom()});
      send_sample(d);
    end
  endtask

  initial begin
    est_x = 0; est_y = 0; unc_x = 0; unc_y = 0; off_x = 0; off_y = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    write_offset(itkf_pkg::CfgGyroOffX, 16'd0);
    write_offset(itkf_pkg::CfgGyroOffY, 16'd0);
    test_random(250, 1'b0);
    drain();
    write_offset(itkf_pkg::CfgGyroOffX, 16'($urandom_range(0, 40) - 20));
    write_offset(itkf_pkg::CfgGyroOffY, 16'($urandom()));
    test_random(250, 1'b0);
    drain();
    write_offset(itkf_pkg::CfgGyroOffX, 16'($urandom()));
    write_offset(itkf_pkg::CfgGyroOffY, 16'($urandom_range(0, 40) - 20));
    quiet = 1'b1;
    test_random(200, 1'b1);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
